[src/ecups_pkg.sv]
// Shared types and constants for the engine controller poll sequencer.
// No dependencies; compile before the interfaces and the top level.
package ecups_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 10;

    // One 100 m odometer count in km/h * ms units.
    localparam logic [19:0] METER_MS_PER_COUNT = 20'd360000;
    localparam logic [23:0] ODO_MAX            = 24'hFFFFFF;

    localparam logic [7:0] KIND_UNUSED = 8'd0;
    localparam logic [7:0] KIND_RAM    = 8'd1;
    localparam logic [7:0] KIND_PRESET = 8'd2;

    localparam logic [9:0] RST_SAMPLE_MS      = 10'd40;
    localparam logic [7:0] RST_WATCHDOG_LIMIT = 8'd3;
    localparam logic [4:0] RST_SPEED_ENTRY    = 5'd7;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_REPLY = 2'd1,
        REQ_WRITE = 2'd2,
        REQ_READ  = 2'd3
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WATCHDOG_LIMIT = 2'd0,
        CFG_SAMPLE_MS      = 2'd1,
        CFG_SPEED_ENTRY    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] kind;
        logic [7:0] addr_high;
        logic [7:0] addr_low;
        logic [7:0] period;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_DIV,
        ST_MUL,
        ST_ACC,
        ST_RD_WAIT,
        ST_OUT
    } t_state;

endpackage

[src/ecups_in_if.sv]
// Request channel of the poll sequencer: valid/ready plus one request item.
// No dependencies.
interface ecups_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] rx_byte;
    logic [4:0] entry_index;
    logic [7:0] entry_kind;
    logic [7:0] entry_addr_high;
    logic [7:0] entry_addr_low;
    logic [7:0] entry_period;

    modport source (
        output valid, req_type, rx_byte, entry_index, entry_kind,
               entry_addr_high, entry_addr_low, entry_period,
        input  ready
    );
    modport sink (
        input  valid, req_type, rx_byte, entry_index, entry_kind,
               entry_addr_high, entry_addr_low, entry_period,
        output ready
    );
endinterface

[src/ecups_out_if.sv]
// Result channel of the poll sequencer: valid/ready plus one result item.
// No dependencies.
interface ecups_out_if;
    logic        valid;
    logic        ready;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        last;
    logic        fetch_pending;
    logic [23:0] odometer;
    logic [7:0]  read_value;

    modport source (
        output valid, tx_valid, tx_byte, last, fetch_pending, odometer, read_value,
        input  ready
    );
    modport sink (
        input  valid, tx_valid, tx_byte, last, fetch_pending, odometer, read_value,
        output ready
    );
endinterface

[src/ecu_poll_sequencer_with_odometer.sv]
// Engine controller poll sequencer with odometer: top level, on ecups_pkg and both interfaces.
// To the first result: a write goes straight out, a read via ST_RD_WAIT; a tick that starts a
// fetch or a reply to a pending one scans (ST_SCAN_RD, ST_SCAN_CHK, a bit-serial period check
// on the shared divider per live entry; a speed reply first does ST_MUL, ST_ACC). Then 1 to 3
// results, one per cycle while the sink is ready; the next request is taken in the cycle after
// the last. Reset (synchronous, active low) empties the tables at once via valid flags.
module ecu_poll_sequencer_with_odometer #(
    parameter int unsigned NUM_SENSORS      = 32,
    parameter int unsigned SLICES_PER_FRAME = 10
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ecups_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ecups_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    ecups_in_if.sink                           i_req,
    ecups_out_if.source                        o_rsp
);

    // Table address, scan position (one extra code for idle), slice and divider count widths.
    localparam int unsigned IW = $clog2(NUM_SENSORS);
    localparam int unsigned PW = $clog2(NUM_SENSORS + 1);
    localparam int unsigned SW = $clog2(SLICES_PER_FRAME + 1);
    localparam int unsigned CW = $clog2(SW + 1);
    // Common width for comparing 5-bit indexes against table positions.
    localparam int unsigned XW = (PW > 5) ? PW : 5;

    localparam logic [PW-1:0] POS_IDLE = PW'(NUM_SENSORS);

    // ------------------------------------------------------------------
    // State and configuration
    // ------------------------------------------------------------------
    ecups_pkg::t_state r_state, n_state;

    logic [7:0]        r_wdog_limit;
    logic [9:0]        r_sample_ms;
    logic [4:0]        r_speed_entry;

    logic [PW-1:0]     r_pos;
    logic [7:0]        r_wait;
    logic [SW-1:0]     r_slice;
    logic [23:0]       r_odo;
    logic [18:0]       r_dist_rem;

    logic [NUM_SENSORS-1:0] r_ent_vld;
    logic [NUM_SENSORS-1:0] r_rep_vld;

    // Result staging
    logic [1:0]        r_tx_n;
    logic [1:0]        r_k;
    logic [7:0]        r_txb [3];
    logic [7:0]        r_read_val;

    // Divider, multiplier and latched reply byte
    logic [SW-1:0]     r_dq;
    logic [7:0]        r_rem;
    logic [CW-1:0]     r_cnt;
    logic [7:0]        r_rx;
    logic [17:0]       r_prod;

    // Memories and their registered read ports
    ecups_pkg::t_entry r_ent_mem [NUM_SENSORS];
    logic [7:0]        r_rep_mem [NUM_SENSORS];
    ecups_pkg::t_entry r_ent_q;
    logic              r_ent_ok;
    logic [7:0]        r_rep_q;
    logic              r_rep_ok;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic              in_xfer, out_xfer;
    logic              pending;
    logic              is_speed;
    logic [XW-1:0]     req_idx_x;
    logic [IW-1:0]     req_addr;
    logic              req_idx_ok;
    logic [IW-1:0]     pos_addr;
    ecups_pkg::t_entry ent;
    logic              ent_skip;
    logic [8:0]        div_sh;
    logic [7:0]        div_nrem;
    logic              div_last;
    logic [19:0]       acc_sum;
    logic              acc_wrap;
    logic              out_last;
    logic              ent_we, ent_re, rep_we, rep_re;
    logic [SW-1:0]     slice_next;

    assign in_xfer   = i_req.valid && i_req.ready;
    assign out_xfer  = o_rsp.valid && o_rsp.ready;
    assign pending   = (r_pos < POS_IDLE);
    assign is_speed  = (XW'(r_pos) == XW'(r_speed_entry));
    assign req_idx_x = XW'(i_req.entry_index);
    assign req_addr  = IW'(req_idx_x);
    assign req_idx_ok = (req_idx_x < XW'(NUM_SENSORS));
    assign pos_addr  = r_pos[IW-1:0];

    // An entry never written reads as all zero.
    assign ent      = r_ent_ok ? r_ent_q : '0;
    assign ent_skip = (ent.kind == ecups_pkg::KIND_UNUSED) || (ent.period == 8'd0);

    // One restoring step of slice % period per cycle, MSB first.
    assign div_sh   = {r_rem, r_dq[SW-1]};
    assign div_nrem = (div_sh >= {1'b0, ent.period}) ? 8'(div_sh - {1'b0, ent.period})
                                                     : div_sh[7:0];
    assign div_last = (r_cnt == CW'(SW - 1));

    // Remainder stays below twice the count size, so one subtract suffices.
    assign acc_sum  = 20'(r_dist_rem) + 20'(r_prod);
    assign acc_wrap = (acc_sum >= ecups_pkg::METER_MS_PER_COUNT);

    assign out_last = (r_tx_n == 2'd0) || (r_k == 2'(r_tx_n - 2'd1));

    assign slice_next = (r_slice >= SW'(SLICES_PER_FRAME)) ? SW'(1) : SW'(r_slice + SW'(1));

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ecups_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    unique case (ecups_pkg::t_req'(i_req.req_type))
                        ecups_pkg::REQ_TICK:
                            n_state = pending ? ecups_pkg::ST_OUT : ecups_pkg::ST_SCAN_RD;
                        ecups_pkg::REQ_REPLY: begin
                            if (!pending)
                                n_state = ecups_pkg::ST_OUT;
                            else if (is_speed)
                                n_state = ecups_pkg::ST_MUL;
                            else
                                n_state = ecups_pkg::ST_SCAN_RD;
                        end
                        ecups_pkg::REQ_WRITE: n_state = ecups_pkg::ST_OUT;
                        ecups_pkg::REQ_READ:  n_state = ecups_pkg::ST_RD_WAIT;
                        default:              n_state = ecups_pkg::ST_OUT;
                    endcase
                end
            end
            ecups_pkg::ST_SCAN_RD:
                n_state = pending ? ecups_pkg::ST_SCAN_CHK : ecups_pkg::ST_OUT;
            ecups_pkg::ST_SCAN_CHK:
                n_state = ent_skip ? ecups_pkg::ST_SCAN_RD : ecups_pkg::ST_DIV;
            ecups_pkg::ST_DIV: begin
                if (div_last)
                    n_state = (div_nrem == 8'd0) ? ecups_pkg::ST_OUT : ecups_pkg::ST_SCAN_RD;
            end
            ecups_pkg::ST_MUL:     n_state = ecups_pkg::ST_ACC;
            ecups_pkg::ST_ACC:     n_state = ecups_pkg::ST_SCAN_RD;
            ecups_pkg::ST_RD_WAIT: n_state = ecups_pkg::ST_OUT;
            ecups_pkg::ST_OUT: begin
                if (out_xfer && out_last)
                    n_state = ecups_pkg::ST_IDLE;
            end
            default: n_state = ecups_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake and memory strobes
    // ------------------------------------------------------------------
    always_comb begin
        i_req.ready = (r_state == ecups_pkg::ST_IDLE);
        o_rsp.valid = (r_state == ecups_pkg::ST_OUT);
        ent_we = in_xfer && (ecups_pkg::t_req'(i_req.req_type) == ecups_pkg::REQ_WRITE)
                 && req_idx_ok;
        rep_re = in_xfer && (ecups_pkg::t_req'(i_req.req_type) == ecups_pkg::REQ_READ);
        rep_we = in_xfer && (ecups_pkg::t_req'(i_req.req_type) == ecups_pkg::REQ_REPLY)
                 && pending;
        ent_re = (r_state == ecups_pkg::ST_SCAN_RD) && pending;
    end

    // Result payload: all fields are derived combinationally from held registers.
    assign o_rsp.tx_valid      = (r_tx_n != 2'd0);
    assign o_rsp.tx_byte       = (r_tx_n != 2'd0) ? r_txb[r_k] : 8'd0;
    assign o_rsp.last          = out_last;
    assign o_rsp.fetch_pending = pending;
    assign o_rsp.odometer      = r_odo;
    assign o_rsp.read_value    = r_read_val;

    // ------------------------------------------------------------------
    // Memories: single write port, registered read port each
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (ent_we)
            r_ent_mem[req_addr] <= '{kind:      i_req.entry_kind,
                                     addr_high: i_req.entry_addr_high,
                                     addr_low:  i_req.entry_addr_low,
                                     period:    i_req.entry_period};
        if (ent_re)
            r_ent_q <= r_ent_mem[pos_addr];
    end

    always_ff @(posedge i_clk) begin
        if (rep_we)
            r_rep_mem[pos_addr] <= i_req.rx_byte;
        if (rep_re)
            r_rep_q <= r_rep_mem[req_addr];
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ecups_pkg::ST_IDLE;
            r_wdog_limit  <= ecups_pkg::RST_WATCHDOG_LIMIT;
            r_sample_ms   <= ecups_pkg::RST_SAMPLE_MS;
            r_speed_entry <= ecups_pkg::RST_SPEED_ENTRY;
            r_pos         <= POS_IDLE;
            r_wait        <= 8'd0;
            r_slice       <= '0;
            r_odo         <= 24'd0;
            r_dist_rem    <= 19'd0;
            r_ent_vld     <= '0;
            r_rep_vld     <= '0;
            r_ent_ok      <= 1'b0;
            r_rep_ok      <= 1'b0;
            r_tx_n        <= 2'd0;
            r_k           <= 2'd0;
            r_cnt         <= '0;
        end else begin
            r_state <= n_state;

            // Configuration writes; an index beyond the list is dropped.
            if (i_cfg_we) begin
                if (i_cfg_idx == ecups_pkg::CFG_WATCHDOG_LIMIT)
                    r_wdog_limit <= i_cfg_data[7:0];
                if (i_cfg_idx == ecups_pkg::CFG_SAMPLE_MS)
                    r_sample_ms <= i_cfg_data;
                if (i_cfg_idx == ecups_pkg::CFG_SPEED_ENTRY)
                    r_speed_entry <= i_cfg_data[4:0];
            end

            if (ent_we)
                r_ent_vld[req_addr] <= 1'b1;
            if (rep_we)
                r_rep_vld[pos_addr] <= 1'b1;
            if (ent_re)
                r_ent_ok <= r_ent_vld[pos_addr];
            if (rep_re)
                r_rep_ok <= req_idx_ok && r_rep_vld[req_addr];

            unique case (r_state)
                ecups_pkg::ST_IDLE: begin
                    if (in_xfer) begin
                        r_tx_n <= 2'd0;
                        r_k    <= 2'd0;
                        if (ecups_pkg::t_req'(i_req.req_type) == ecups_pkg::REQ_TICK) begin
                            r_slice <= slice_next;
                            if (pending) begin
                                // Watchdog: count, then abandon the fetch.
                                if (r_wait < r_wdog_limit)
                                    r_wait <= r_wait + 8'd1;
                                else
                                    r_pos <= POS_IDLE;
                            end else begin
                                r_wait <= 8'd0;
                                r_pos  <= '0;
                            end
                        end else if (rep_we && !is_speed) begin
                            r_pos <= r_pos + PW'(1);
                        end
                    end
                end
                ecups_pkg::ST_SCAN_CHK: begin
                    r_cnt <= '0;
                    if (ent_skip)
                        r_pos <= r_pos + PW'(1);
                end
                ecups_pkg::ST_DIV: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (div_last) begin
                        if (div_nrem == 8'd0) begin
                            // Hit: queue the request bytes for this kind.
                            if (ent.kind == ecups_pkg::KIND_PRESET)
                                r_tx_n <= 2'd1;
                            else if (ent.kind == ecups_pkg::KIND_RAM)
                                r_tx_n <= 2'd3;
                            else
                                r_tx_n <= 2'd0;
                        end else begin
                            r_pos <= r_pos + PW'(1);
                        end
                    end
                end
                ecups_pkg::ST_ACC: begin
                    if (acc_wrap) begin
                        r_dist_rem <= 19'(acc_sum - ecups_pkg::METER_MS_PER_COUNT);
                        if (r_odo < ecups_pkg::ODO_MAX)
                            r_odo <= r_odo + 24'd1;
                    end else begin
                        r_dist_rem <= 19'(acc_sum);
                    end
                    r_pos <= r_pos + PW'(1);
                end
                ecups_pkg::ST_OUT: begin
                    if (out_xfer && !out_last)
                        r_k <= r_k + 2'd1;
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Payload registers (no reset needed)
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ecups_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    r_read_val <= 8'd0;
                    r_rx       <= i_req.rx_byte;
                end
            end
            ecups_pkg::ST_SCAN_CHK: begin
                r_dq  <= r_slice;
                r_rem <= 8'd0;
            end
            ecups_pkg::ST_DIV: begin
                r_dq  <= r_dq << 1;
                r_rem <= div_nrem;
                if (div_last) begin
                    if (ent.kind == ecups_pkg::KIND_PRESET) begin
                        r_txb[0] <= ent.addr_high;
                    end else begin
                        r_txb[0] <= ecups_pkg::KIND_RAM;
                        r_txb[1] <= ent.addr_high;
                        r_txb[2] <= ent.addr_low;
                    end
                end
            end
            ecups_pkg::ST_MUL:
                r_prod <= {10'd0, r_rx} * {8'd0, r_sample_ms};
            ecups_pkg::ST_RD_WAIT:
                r_read_val <= r_rep_ok ? r_rep_q : 8'd0;
            default: ;
        endcase
    end

endmodule
